// ===== sv/irpfd_pkg.sv =====
// Shared types and constants for the infrared pulse frame decoder.
package irpfd_pkg;

    // Frame phase of the decoder
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HSPACE = 3'd1,
        PH_BMARK  = 3'd2,
        PH_BSPACE = 3'd3,
        PH_FINAL  = 3'd4
    } phase_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_HEADER  = 2'd1,
        ST_TIMEOUT = 2'd2,
        ST_PROTO   = 2'd3
    } status_t;

    // Configuration register indexes (byte address / 4)
    localparam logic [2:0] REG_HDR_MARK  = 3'd0;
    localparam logic [2:0] REG_HDR_SPACE = 3'd1;
    localparam logic [2:0] REG_ONE_SPACE = 3'd2;
    localparam logic [2:0] REG_ZERO_SPACE = 3'd3;
    localparam logic [2:0] REG_TOL_PCT   = 3'd4;

    // Window lanes, one per nominal length
    localparam int unsigned NUM_WIN  = 4;
    localparam int unsigned WIN_HMARK = 0;
    localparam int unsigned WIN_HSPACE = 1;
    localparam int unsigned WIN_ONE   = 2;
    localparam int unsigned WIN_ZERO  = 3;

    // Effective length width: every limit fits in 14 bits
    localparam int unsigned LEN_W = 14;
    localparam logic [LEN_W-1:0] LIM_HMARK  = 14'd12000;
    localparam logic [LEN_W-1:0] LIM_HSPACE = 14'd6000;
    localparam logic [LEN_W-1:0] LIM_BMARK  = 14'd1500;
    localparam logic [LEN_W-1:0] LIM_BSPACE = 14'd3000;
    localparam logic [LEN_W-1:0] LIM_FINAL  = 14'd1000;

    // Divide by 100 as multiply by ceil(2^30/100) and shift; exact for products below 2^23
    localparam int unsigned TOL_SHIFT = 30;
    localparam logic [23:0] TOL_RECIP = 24'd10737419;

    localparam int unsigned BITS_PER_FRAME = 32;

    // Check a length against a tolerance window
    function automatic logic in_window(logic [LEN_W-1:0] len, logic [15:0] lo,
                                       logic [17:0] hi);
        logic ge_lo;
        logic le_hi;
        ge_lo = {2'b00, len} >= lo;
        le_hi = {4'b0000, len} <= hi;
        return ge_lo && le_hi;
    endfunction

endpackage

// ===== sv/ir_pulse_frame_decoder.sv =====
// Top level of the infrared pulse frame decoder: config, window bounds, frame FSM, result queue.
//
//  Channel   Direction  Handshake               Payload
//  ------    ---------  ---------------------   ---------------------------------
//  in        sink       in_valid / in_ready     line_level, pulse_us
//  out       source     out_valid / out_ready   status, address, command
//  apb       sink       psel/penable/pready     paddr, pwrite, pwdata, prdata
//
//  One pulse word is taken per cycle while in_ready is high; the frame state updates at the
//  accepting edge and a result, if any, enters the head entry, or the skid entry while the head
//  is full. A two-entry result queue keeps input flowing while one result waits. After reset and
//  after every register write, in_ready stays low while the tolerance bounds pass through their
//  multiply pipeline. Reset is asynchronous and active low; it returns the decoder to idle.
module ir_pulse_frame_decoder
    import irpfd_pkg::*;
#(
    parameter int unsigned DURATION_WIDTH = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // pulse input
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      line_level,
    input  logic [DURATION_WIDTH-1:0] pulse_us,
    // result output
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                status,
    output logic [7:0]                address,
    output logic [7:0]                command,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [4:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] hdr_mark_reg;
    logic [15:0] hdr_space_reg;
    logic [15:0] one_space_reg;
    logic [15:0] zero_space_reg;
    logic [6:0]  tol_pct_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    logic [1:0]  busy_cnt_reg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_mark_reg   <= 16'd9000;
            hdr_space_reg  <= 16'd4500;
            one_space_reg  <= 16'd1687;
            zero_space_reg <= 16'd562;
            tol_pct_reg    <= 7'd25;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_HDR_MARK:   hdr_mark_reg   <= pwdata[15:0];
                REG_HDR_SPACE:  hdr_space_reg  <= pwdata[15:0];
                REG_ONE_SPACE:  one_space_reg  <= pwdata[15:0];
                REG_ZERO_SPACE: zero_space_reg <= pwdata[15:0];
                REG_TOL_PCT:    tol_pct_reg    <= pwdata[6:0];
                default:        ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (cfg_idx)
            REG_HDR_MARK:   prdata = {16'd0, hdr_mark_reg};
            REG_HDR_SPACE:  prdata = {16'd0, hdr_space_reg};
            REG_ONE_SPACE:  prdata = {16'd0, one_space_reg};
            REG_ZERO_SPACE: prdata = {16'd0, zero_space_reg};
            REG_TOL_PCT:    prdata = {25'd0, tol_pct_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // Hold input off until the bound pipeline has settled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_cnt_reg <= 2'd3;
        else if (cfg_wr)
            busy_cnt_reg <= 2'd3;
        else if (busy_cnt_reg != 2'd0)
            busy_cnt_reg <= busy_cnt_reg - 2'd1;
    end

    // ------------------------------------------------------------------
    // Tolerance window bounds: nominal * pct, / 100, then lo / hi
    // ------------------------------------------------------------------
    logic [15:0] nominal [NUM_WIN];
    logic [22:0] prod_reg [NUM_WIN];
    logic [16:0] tol_reg [NUM_WIN];
    logic [15:0] win_lo_reg [NUM_WIN];
    logic [17:0] win_hi_reg [NUM_WIN];

    assign nominal[WIN_HMARK]  = hdr_mark_reg;
    assign nominal[WIN_HSPACE] = hdr_space_reg;
    assign nominal[WIN_ONE]    = one_space_reg;
    assign nominal[WIN_ZERO]   = zero_space_reg;

    for (genvar w = 0; w < NUM_WIN; w++)
    begin : g_win
        logic [46:0] recip_prod;

        assign recip_prod = {24'd0, prod_reg[w]} * {23'd0, TOL_RECIP};

        always_ff @(posedge clk)
        begin
            prod_reg[w] <= {7'd0, nominal[w]} * {16'd0, tol_pct_reg};
            tol_reg[w]  <= recip_prod[TOL_SHIFT+16:TOL_SHIFT];
            // clamp the lower bound at zero when the tolerance exceeds nominal
            if (tol_reg[w] > {1'b0, nominal[w]})
                win_lo_reg[w] <= 16'd0;
            else
                win_lo_reg[w] <= nominal[w] - tol_reg[w][15:0];
            win_hi_reg[w] <= {2'b00, nominal[w]} + {1'b0, tol_reg[w]};
        end
    end

    // ------------------------------------------------------------------
    // Pulse classification
    // ------------------------------------------------------------------
    phase_t      phase_reg;
    phase_t      phase_next;
    logic [5:0]  bit_count_reg;
    logic [5:0]  bit_count_next;
    logic [31:0] frame_shift_reg;
    logic [31:0] frame_shift_next;
    logic [5:0]  bit_count_inc;
    logic        acc;

    logic [LEN_W-1:0] d_hmark;
    logic [LEN_W-1:0] d_hspace;
    logic [LEN_W-1:0] d_bmark;
    logic [LEN_W-1:0] d_bspace;
    logic [LEN_W-1:0] d_final;
    logic             hmark_ok;
    logic             hspace_ok;
    logic             bspace_one;
    logic             bspace_zero;
    logic             check_ok;

    assign acc = in_valid && in_ready;

    // Zero the length on a wrong level or on a timeout
    assign d_hmark  = (!line_level && pulse_us <= DURATION_WIDTH'(LIM_HMARK))
                      ? pulse_us[LEN_W-1:0] : '0;
    assign d_hspace = (line_level && pulse_us <= DURATION_WIDTH'(LIM_HSPACE))
                      ? pulse_us[LEN_W-1:0] : '0;
    assign d_bmark  = (!line_level && pulse_us <= DURATION_WIDTH'(LIM_BMARK))
                      ? pulse_us[LEN_W-1:0] : '0;
    assign d_bspace = (line_level && pulse_us <= DURATION_WIDTH'(LIM_BSPACE))
                      ? pulse_us[LEN_W-1:0] : '0;
    assign d_final  = (!line_level && pulse_us <= DURATION_WIDTH'(LIM_FINAL))
                      ? pulse_us[LEN_W-1:0] : '0;

    assign hmark_ok  = (d_hmark != '0) &&
                       in_window(d_hmark, win_lo_reg[WIN_HMARK], win_hi_reg[WIN_HMARK]);
    assign hspace_ok = (d_hspace != '0) &&
                       in_window(d_hspace, win_lo_reg[WIN_HSPACE], win_hi_reg[WIN_HSPACE]);
    assign bspace_one  = in_window(d_bspace, win_lo_reg[WIN_ONE], win_hi_reg[WIN_ONE]);
    assign bspace_zero = in_window(d_bspace, win_lo_reg[WIN_ZERO], win_hi_reg[WIN_ZERO]);

    // Address and command must each match their inverted copy
    assign check_ok = (~frame_shift_reg[31:24] == frame_shift_reg[23:16]) &&
                      (~frame_shift_reg[15:8] == frame_shift_reg[7:0]);

    assign bit_count_inc = bit_count_reg + 6'd1;

    // ------------------------------------------------------------------
    // Frame state: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next       = phase_reg;
        bit_count_next   = bit_count_reg;
        frame_shift_next = frame_shift_reg;
        unique case (phase_reg)
            PH_HSPACE:
            begin
                phase_next       = hspace_ok ? PH_BMARK : PH_IDLE;
                bit_count_next   = 6'd0;
                frame_shift_next = 32'd0;
            end
            PH_BMARK:
            begin
                if (d_bmark != '0)
                    phase_next = PH_BSPACE;
                else
                begin
                    phase_next       = PH_IDLE;
                    bit_count_next   = 6'd0;
                    frame_shift_next = 32'd0;
                end
            end
            PH_BSPACE:
            begin
                if (d_bspace != '0 && (bspace_one || bspace_zero))
                begin
                    frame_shift_next = {frame_shift_reg[30:0], bspace_one};
                    bit_count_next   = bit_count_inc;
                    phase_next       = bit_count_inc[5] ? PH_FINAL : PH_BMARK;
                end
                else
                begin
                    phase_next       = PH_IDLE;
                    bit_count_next   = 6'd0;
                    frame_shift_next = 32'd0;
                end
            end
            PH_FINAL:
            begin
                phase_next       = PH_IDLE;
                bit_count_next   = 6'd0;
                frame_shift_next = 32'd0;
            end
            default:
            begin
                // ignore a space while idle
                phase_next = PH_IDLE;
                if (!line_level)
                begin
                    phase_next       = hmark_ok ? PH_HSPACE : PH_IDLE;
                    bit_count_next   = 6'd0;
                    frame_shift_next = 32'd0;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Frame state: result word
    // ------------------------------------------------------------------
    logic    res_valid;
    status_t res_status;
    logic [7:0] res_addr;
    logic [7:0] res_cmd;

    always_comb
    begin
        res_valid  = 1'b0;
        res_status = ST_OK;
        res_addr   = 8'd0;
        res_cmd    = 8'd0;
        unique case (phase_reg)
            PH_HSPACE:
            begin
                res_valid  = !hspace_ok;
                res_status = ST_HEADER;
            end
            PH_BMARK:
            begin
                res_valid  = (d_bmark == '0);
                res_status = ST_TIMEOUT;
            end
            PH_BSPACE:
            begin
                if (d_bspace == '0)
                begin
                    res_valid  = 1'b1;
                    res_status = ST_TIMEOUT;
                end
                else if (!bspace_one && !bspace_zero)
                begin
                    res_valid  = 1'b1;
                    res_status = ST_PROTO;
                end
            end
            PH_FINAL:
            begin
                res_valid = 1'b1;
                if (d_final == '0)
                    res_status = ST_TIMEOUT;
                else if (!check_ok)
                    res_status = ST_PROTO;
                else
                begin
                    res_addr = frame_shift_reg[31:24];
                    res_cmd  = frame_shift_reg[15:8];
                end
            end
            default:
            begin
                res_valid  = !line_level && !hmark_ok;
                res_status = ST_HEADER;
            end
        endcase
    end

    // Advance the frame state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            bit_count_reg   <= 6'd0;
            frame_shift_reg <= 32'd0;
        end
        else if (acc)
        begin
            phase_reg       <= phase_next;
            bit_count_reg   <= bit_count_next;
            frame_shift_reg <= frame_shift_next;
        end
    end

    // ------------------------------------------------------------------
    // Result queue: head register plus one skid entry
    // ------------------------------------------------------------------
    logic       out_valid_reg;
    status_t    out_status_reg;
    logic [7:0] out_addr_reg;
    logic [7:0] out_cmd_reg;
    logic       skid_valid_reg;
    status_t    skid_status_reg;
    logic [7:0] skid_addr_reg;
    logic [7:0] skid_cmd_reg;
    logic       push;
    logic       pop;

    assign push = acc && res_valid;
    assign pop  = out_valid_reg && out_ready;

    // Track occupancy of both entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= skid_valid_reg && push;
        end
        else if (push)
            skid_valid_reg <= 1'b1;
    end

    // Move payload into the head or the skid entry
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_status_reg <= skid_status_reg;
                out_addr_reg   <= skid_addr_reg;
                out_cmd_reg    <= skid_cmd_reg;
            end
            else if (push)
            begin
                out_status_reg <= res_status;
                out_addr_reg   <= res_addr;
                out_cmd_reg    <= res_cmd;
            end
        end
        if (push && (skid_valid_reg || (out_valid_reg && !pop)))
        begin
            skid_status_reg <= res_status;
            skid_addr_reg   <= res_addr;
            skid_cmd_reg    <= res_cmd;
        end
    end

    assign in_ready  = (busy_cnt_reg == 2'd0) && !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign address   = out_addr_reg;
    assign command   = out_cmd_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a word while the head is empty");

    a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> !in_ready)
        else $error("input taken while window bounds recompute");

    a_final_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FINAL) |-> (bit_count_reg == 6'd32))
        else $error("final mark phase entered without a full frame");

    a_error_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_OK) |->
        (out_addr_reg == 8'd0 && out_cmd_reg == 8'd0))
        else $error("error result carries address or command");

endmodule
